### src/memory_region_table_checker_assert.svh
// assertion macros for the region table checker back end
// expects clk and rst_n in the scope of each use
`ifndef MEMORY_REGION_TABLE_CHECKER_ASSERT_SVH
`define MEMORY_REGION_TABLE_CHECKER_ASSERT_SVH

// condition must hold whenever the antecedent holds in the same cycle
`define MRTC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// condition must hold in the cycle after the antecedent
`define MRTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### src/mrtc_pkg.sv
// shared types and constants for the memory region table checker
// no dependencies
package mrtc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_GET   = 2'd2;

  // memory type codes
  localparam logic [1:0] MT_ANY     = 2'd0;
  localparam logic [1:0] MT_RAM     = 2'd1;
  localparam logic [1:0] MT_EEPROM  = 2'd2;
  localparam logic [1:0] MT_UNKNOWN = 2'd3;

  // word size and attribute codes
  localparam logic [1:0] WS_NONE    = 2'd0;
  localparam logic [1:0] ATTR_NONE  = 2'd0;
  localparam logic [1:0] ATTR_RW    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_BAD_RANGE = 3'd3,
    ST_BAD_WSIZE = 3'd4,
    ST_BAD_ATTR  = 3'd5
  } status_t;

  // work the back end has to do for one item
  typedef enum logic [1:0] {
    OP_RESP = 2'd0,
    OP_SET  = 2'd1,
    OP_GET  = 2'd2,
    OP_CHK  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    status_t           status;
    logic [IDX_W-1:0]  idx;
    logic [1:0]        mtype;
    logic [31:0]       addr;
    logic [31:0]       size;
    logic [31:0]       last;
    logic [1:0]        wsize;
    logic [1:0]        attr;
  } op_t;

  // one table entry, end address kept alongside start and size
  typedef struct packed {
    logic [1:0]  mtype;
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] last;
    logic [1:0]  wsize;
    logic [1:0]  attr;
  } region_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  etype;
    logic [31:0] start;
    logic [31:0] size;
    logic [1:0]  wsize;
    logic [1:0]  attr;
  } res_t;

endpackage

### src/memory_region_table_checker.sv
// set, get-index error, bad check type/wrap, unknown command: registered on taking the item
// get: via the registered table read; check: entries scanned in order up to the first match
// throughput: 1 item/cycle for set and direct errors while results are popped; get and check
// hold the back end till their result is registered; the single table port reads one entry a cycle
// reset: all entries read as invalid (start 0, size 0, word size none, read-write), queues empty
// top level: front classifier, op queue, back end with the region table; depends on mrtc_pkg
module memory_region_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_index,
  input  logic [1:0]  in_mem_type,
  input  logic [31:0] in_address,
  input  logic [31:0] in_size,
  input  logic [1:0]  in_word_size,
  input  logic [1:0]  in_attributes,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [1:0]  out_entry_type,
  output logic [31:0] out_entry_start,
  output logic [31:0] out_entry_size,
  output logic [1:0]  out_entry_word_size,
  output logic [1:0]  out_entry_attributes
);
  import mrtc_pkg::*;

  op_t  fe_op;
  op_t  q_item;
  logic q_full, q_empty, q_pop;
  logic res_valid;
  res_t res;

  // front: classify
  mrtc_front u_front (
    .in_command    (in_command),
    .in_index      (in_index),
    .in_mem_type   (in_mem_type),
    .in_address    (in_address),
    .in_size       (in_size),
    .in_word_size  (in_word_size),
    .in_attributes (in_attributes),
    .op            (fe_op)
  );

  // op queue
  mrtc_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (fe_op),
    .pop      (q_pop),
    .item_out (q_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: table and execution
  mrtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign full                 = q_full;
  assign empty                = !res_valid;
  assign out_status           = res.status;
  assign out_entry_type       = res.etype;
  assign out_entry_start      = res.start;
  assign out_entry_size       = res.size;
  assign out_entry_word_size  = res.wsize;
  assign out_entry_attributes = res.attr;

endmodule

### src/mrtc_front.sv
// front end: decodes and classifies an incoming item into a back-end op
// depends on mrtc_pkg
module mrtc_front (
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_index,
  input  logic [1:0]       in_mem_type,
  input  logic [31:0]      in_address,
  input  logic [31:0]      in_size,
  input  logic [1:0]       in_word_size,
  input  logic [1:0]       in_attributes,
  output mrtc_pkg::op_t    op
);
  import mrtc_pkg::*;

  localparam logic [8:0] ENTRIES_LIM = 9'(TABLE_ENTRIES);

  logic [31:0] last;
  logic        wrap;
  logic        idx_bad;
  logic        type_bad;

  // span end and wrap test
  assign last     = in_address + in_size - 32'd1;
  assign wrap     = last < in_address;
  assign idx_bad  = {1'b0, in_index} >= ENTRIES_LIM;
  assign type_bad = (in_mem_type != MT_RAM) && (in_mem_type != MT_EEPROM);

  // classify by command, errors found here answer directly
  always_comb begin
    op.kind   = OP_RESP;
    op.status = ST_OK;
    op.idx    = in_index[IDX_W-1:0];
    op.mtype  = in_mem_type;
    op.addr   = in_address;
    op.size   = in_size;
    op.last   = last;
    op.wsize  = in_word_size;
    op.attr   = in_attributes;
    case (in_command)
      CMD_CHECK: begin
        if (in_mem_type == MT_UNKNOWN) begin
          op.status = ST_BAD_TYPE;
        end else if (wrap) begin
          op.status = ST_BAD_RANGE;
        end else begin
          op.kind = OP_CHK;
        end
      end
      CMD_SET: begin
        if (idx_bad) begin
          op.status = ST_BAD_RANGE;
        end else if (type_bad) begin
          op.status = ST_BAD_TYPE;
        end else if (in_word_size == WS_NONE) begin
          op.status = ST_BAD_WSIZE;
        end else if (in_attributes == ATTR_NONE) begin
          op.status = ST_BAD_ATTR;
        end else begin
          op.kind = OP_SET;
        end
      end
      CMD_GET: begin
        if (idx_bad) begin
          op.status = ST_BAD_RANGE;
        end else begin
          op.kind = OP_GET;
        end
      end
      default: begin
        op.status = ST_BAD_TYPE;
      end
    endcase
  end

endmodule

### src/mrtc_opq.sv
// small op queue between the front and back ends
// depends on mrtc_pkg
module mrtc_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrtc_pkg::op_t item_in,
  input  logic          pop,
  output mrtc_pkg::op_t item_out,
  output logic          full,
  output logic          empty
);
  import mrtc_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### src/mrtc_back.sv
// back end: holds the region table, runs set, get and span checks
// depends on mrtc_pkg and memory_region_table_checker_assert.svh
module mrtc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  mrtc_pkg::op_t q_item,
  output logic          q_pop,
  input  logic          res_pop,
  output logic          res_valid,
  output mrtc_pkg::res_t res
);
  import mrtc_pkg::*;

  `include "memory_region_table_checker_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET_RD,
    S_SCAN
  } state_t;

  // region table and per-entry valid bits
  region_t                 mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r, vld_nxt;
  region_t                 rd_ent_r;
  logic                    rd_vld_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t          verdict_r, verdict_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic [31:0]      chk_addr_r, chk_addr_nxt;
  logic [31:0]      chk_last_r, chk_last_nxt;
  logic [1:0]       chk_want_r, chk_want_nxt;

  logic             out_free;
  logic             start;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  region_t          wr_ent;
  status_t          ent_status;
  logic             scan_hit;
  logic             scan_last;

  localparam res_t RES_ZERO = '{status: ST_OK, etype: 2'd0, start: 32'd0,
                                size: 32'd0, wsize: 2'd0, attr: 2'd0};

  assign out_free = !out_valid_r || res_pop;
  assign start    = (state_r == S_IDLE) && !q_empty && out_free;
  assign q_pop    = start;
  assign mem_we   = start && (q_item.kind == OP_SET);

  // single table port: scan counter, entry 0 when a check starts, else the op's index
  always_comb begin
    if (state_r == S_SCAN) begin
      mem_addr = cnt_r[IDX_W-1:0];
    end else if (q_item.kind == OP_CHK) begin
      mem_addr = '0;
    end else begin
      mem_addr = q_item.idx;
    end
  end

  assign wr_ent = '{mtype: q_item.mtype, start: q_item.addr, size: q_item.size,
                    last: q_item.last, wsize: q_item.wsize, attr: q_item.attr};

  // verdict for the entry read last cycle
  always_comb begin
    if (chk_addr_r < rd_ent_r.start || chk_addr_r > rd_ent_r.last) begin
      ent_status = ST_BAD_ADDR;
    end else if (chk_last_r > rd_ent_r.last) begin
      ent_status = ST_BAD_RANGE;
    end else if (chk_want_r == MT_ANY || chk_want_r == rd_ent_r.mtype) begin
      ent_status = ST_OK;
    end else begin
      ent_status = ST_BAD_TYPE;
    end
  end

  assign scan_hit  = rd_vld_r && (ent_status == ST_OK);
  assign scan_last = cnt_r == CNT_W'(TABLE_ENTRIES);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && !res_pop;
    res_nxt       = res_r;
    chk_addr_nxt  = chk_addr_r;
    chk_last_nxt  = chk_last_r;
    chk_want_nxt  = chk_want_r;
    vld_nxt       = vld_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (q_item.kind)
            OP_RESP: begin
              res_nxt        = RES_ZERO;
              res_nxt.status = q_item.status;
              out_valid_nxt  = 1'b1;
            end
            OP_SET: begin
              vld_nxt[q_item.idx] = 1'b1;
              res_nxt             = RES_ZERO;
              out_valid_nxt       = 1'b1;
            end
            OP_GET: begin
              state_nxt = S_GET_RD;
            end
            OP_CHK: begin
              state_nxt    = S_SCAN;
              cnt_nxt      = CNT_W'(1);
              verdict_nxt  = ST_BAD_ADDR;
              chk_addr_nxt = q_item.addr;
              chk_last_nxt = q_item.last;
              chk_want_nxt = q_item.mtype;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_GET_RD: begin
        // an entry never written reads as invalid, read-write
        res_nxt = RES_ZERO;
        if (rd_vld_r) begin
          res_nxt.etype = rd_ent_r.mtype;
          res_nxt.start = rd_ent_r.start;
          res_nxt.size  = rd_ent_r.size;
          res_nxt.wsize = rd_ent_r.wsize;
          res_nxt.attr  = rd_ent_r.attr;
        end else begin
          res_nxt.attr  = ATTR_RW;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_nxt       = RES_ZERO;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (rd_vld_r) begin
            verdict_nxt = ent_status;
          end
          if (scan_last) begin
            res_nxt        = RES_ZERO;
            res_nxt.status = rd_vld_r ? ent_status : verdict_r;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
    end
    verdict_r  <= verdict_nxt;
    res_r      <= res_nxt;
    chk_addr_r <= chk_addr_nxt;
    chk_last_r <= chk_last_nxt;
    chk_want_r <= chk_want_nxt;
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_ent;
    end
    rd_ent_r <= mem[mem_addr];
    rd_vld_r <= vld_r[mem_addr];
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  // checks
  `MRTC_ASSERT_IMPLY(a_pop_only_idle, q_pop, state_r == S_IDLE && !q_empty)
  `MRTC_ASSERT_IMPLY(a_busy_no_result, state_r != S_IDLE, !out_valid_r)
  `MRTC_ASSERT_NEXT(a_get_gives_result, state_r == S_GET_RD, out_valid_r)
  `MRTC_ASSERT_IMPLY(a_scan_cnt_range, state_r == S_SCAN, cnt_r != '0 && cnt_r <= CNT_W'(TABLE_ENTRIES))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for memory_region_table_checker: directed table then random commands
// expected results from a shadow region table or a directed row's own; depends on mrtc_pkg and the rtl
module tb;
  import mrtc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [1:0] REGION_INVALID = 2'd0;
  localparam logic [1:0] WS_BYTE        = 2'd1;
  localparam logic [1:0] WS_WORD        = 2'd2;
  localparam logic [1:0] WS_DWORD       = 2'd3;
  localparam logic [1:0] ATTR_RD        = 2'd1;
  localparam logic [1:0] ATTR_WR        = 2'd2;

  // run shape
  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam int BURST_FROM   = 500;
  localparam int BURST_TO     = 650;
  localparam int PAUSE_AT     = 900;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  index;
    logic [1:0]  mem_type;
    logic [31:0] address;
    logic [31:0] size;
    logic [1:0]  word_size;
    logic [1:0]  attributes;
  } region_cmd_t;

  typedef struct packed {
    region_cmd_t cmd;
    bit          typed;
    res_t        want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_index = '0;
  logic [1:0]  in_mem_type = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_size = '0;
  logic [1:0]  in_word_size = '0;
  logic [1:0]  in_attributes = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_entry_type;
  logic [31:0] out_entry_start;
  logic [31:0] out_entry_size;
  logic [1:0]  out_entry_word_size;
  logic [1:0]  out_entry_attributes;

  // shadow region table
  logic [1:0]  shadow_type  [TABLE_ENTRIES];
  logic [31:0] shadow_start [TABLE_ENTRIES];
  logic [31:0] shadow_size  [TABLE_ENTRIES];
  logic [1:0]  shadow_wsize [TABLE_ENTRIES];
  logic [1:0]  shadow_attr  [TABLE_ENTRIES];

  res_t          pending_results[$];
  directed_row_t directed_rows[$];

  int errors = 0;
  int accepted_items = 0;
  int result_count = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int cmd_count[4];
  int status_seen[6];

  memory_region_table_checker i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_command           (in_command),
    .in_index             (in_index),
    .in_mem_type          (in_mem_type),
    .in_address           (in_address),
    .in_size              (in_size),
    .in_word_size         (in_word_size),
    .in_attributes        (in_attributes),
    .empty                (empty),
    .pop                  (pop),
    .out_status           (out_status),
    .out_entry_type       (out_entry_type),
    .out_entry_start      (out_entry_start),
    .out_entry_size       (out_entry_size),
    .out_entry_word_size  (out_entry_word_size),
    .out_entry_attributes (out_entry_attributes)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("tb: result %0d mismatch on %s: got %h expected %h at %0t",
               result_count, field, got, exp, $time);
  endtask

  task automatic clear_shadow();
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      shadow_type[e]  = REGION_INVALID;
      shadow_start[e] = '0;
      shadow_size[e]  = '0;
      shadow_wsize[e] = WS_NONE;
      shadow_attr[e]  = ATTR_RW;
    end
  endtask

  // span lookup: success on any containing entry of the wanted type,
  // otherwise the verdict of the highest valid entry
  function automatic status_t span_status(input logic [31:0] a, input logic [31:0] n,
                                          input logic [1:0] want);
    logic [31:0] last_a;
    logic [31:0] lo;
    logic [31:0] hi;
    status_t     verdict;
    last_a  = a + n - 32'd1;
    verdict = ST_BAD_ADDR;
    if (want == MT_UNKNOWN) return ST_BAD_TYPE;
    if (last_a < a) return ST_BAD_RANGE;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (shadow_type[e] == REGION_INVALID) continue;
      lo = shadow_start[e];
      hi = shadow_start[e] + shadow_size[e] - 32'd1;
      if (a < lo || a > hi)
        verdict = ST_BAD_ADDR;
      else if (last_a > hi)
        verdict = ST_BAD_RANGE;
      else if (want == MT_ANY || want == shadow_type[e])
        return ST_OK;
      else
        verdict = ST_BAD_TYPE;
    end
    return verdict;
  endfunction

  task automatic predict_region_op(input region_cmd_t c, output res_t r);
    r = '0;
    case (c.command)
      CMD_CHECK: r.status = span_status(c.address, c.size, c.mem_type);
      CMD_SET: begin
        if (c.index >= TABLE_ENTRIES)
          r.status = ST_BAD_RANGE;
        else if (c.mem_type != MT_RAM && c.mem_type != MT_EEPROM)
          r.status = ST_BAD_TYPE;
        else if (c.word_size == WS_NONE)
          r.status = ST_BAD_WSIZE;
        else if (c.attributes == ATTR_NONE)
          r.status = ST_BAD_ATTR;
        else begin
          shadow_type[c.index]  = c.mem_type;
          shadow_start[c.index] = c.address;
          shadow_size[c.index]  = c.size;
          shadow_wsize[c.index] = c.word_size;
          shadow_attr[c.index]  = c.attributes;
          r.status = ST_OK;
        end
      end
      CMD_GET: begin
        if (c.index >= TABLE_ENTRIES)
          r.status = ST_BAD_RANGE;
        else begin
          r.status = ST_OK;
          r.etype  = shadow_type[c.index];
          r.start  = shadow_start[c.index];
          r.size   = shadow_size[c.index];
          r.wsize  = shadow_wsize[c.index];
          r.attr   = shadow_attr[c.index];
        end
      end
      default: r.status = ST_BAD_TYPE;
    endcase
  endtask

  function automatic region_cmd_t mk_cmd(input logic [1:0] c, input logic [7:0] i,
                                         input logic [1:0] t, input logic [31:0] a,
                                         input logic [31:0] n, input logic [1:0] w,
                                         input logic [1:0] at);
    region_cmd_t r;
    r = '{command: c, index: i, mem_type: t, address: a, size: n,
          word_size: w, attributes: at};
    return r;
  endfunction

  function automatic res_t status_only(input status_t st);
    res_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(input region_cmd_t c, input bit typed, input res_t want);
    directed_rows.push_back('{cmd: c, typed: typed, want: want});
  endtask

  // directed rows: reset contents, every rejection code, extremes of the fields
  task automatic load_directed_rows();
    res_t reset_entry;
    reset_entry = '{status: ST_OK, etype: REGION_INVALID, start: 32'd0, size: 32'd0,
                    wsize: WS_NONE, attr: ATTR_RW};
    add_row(mk_cmd(CMD_GET, 8'd0, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b1,
            reset_entry);
    add_row(mk_cmd(CMD_GET, 8'd15, MT_RAM, 32'd0, 32'd0, WS_BYTE, ATTR_RD), 1'b0, '0);
    // empty table: nothing matches
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_ANY, 32'h1000, 32'h10, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_ADDR));
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_ADDR));
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_UNKNOWN, 32'h1000, 32'h10, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_TYPE));
    // wrapping spans
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_RAM, 32'hFFFF_FFF0, 32'h20, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_RANGE));
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_EEPROM, 32'd5, 32'd0, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_RANGE));
    // set rejections in priority order
    add_row(mk_cmd(CMD_SET, 8'd16, MT_RAM, 32'd0, 32'd1, WS_BYTE, ATTR_RD), 1'b1,
            status_only(ST_BAD_RANGE));
    add_row(mk_cmd(CMD_SET, 8'd255, MT_ANY, 32'd0, 32'd1, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_RANGE));
    add_row(mk_cmd(CMD_SET, 8'd3, MT_ANY, 32'd0, 32'd1, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_TYPE));
    add_row(mk_cmd(CMD_SET, 8'd3, MT_UNKNOWN, 32'd0, 32'd1, WS_BYTE, ATTR_RD), 1'b1,
            status_only(ST_BAD_TYPE));
    add_row(mk_cmd(CMD_SET, 8'd3, MT_RAM, 32'd0, 32'd1, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_WSIZE));
    add_row(mk_cmd(CMD_SET, 8'd3, MT_RAM, 32'd0, 32'd1, WS_BYTE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_ATTR));
    add_row(mk_cmd(CMD_GET, 8'd3, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b0, '0);
    add_row(mk_cmd(CMD_GET, 8'd255, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b1,
            status_only(ST_BAD_RANGE));
    add_row(mk_cmd(CMD_UNUSED, 8'hFF, MT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WS_DWORD,
                   ATTR_RW), 1'b1, status_only(ST_BAD_TYPE));
    // real regions, including one ending at the top of the address space
    add_row(mk_cmd(CMD_SET, 8'd0, MT_RAM, 32'h1000, 32'h100, WS_BYTE, ATTR_RD), 1'b1,
            status_only(ST_OK));
    add_row(mk_cmd(CMD_SET, 8'd15, MT_EEPROM, 32'hFFFF_FF00, 32'h100, WS_DWORD, ATTR_RW),
            1'b1, status_only(ST_OK));
    add_row(mk_cmd(CMD_GET, 8'd15, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b0, '0);
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_RAM, 32'h1000, 32'h100, WS_NONE, ATTR_NONE), 1'b0,
            '0);
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_EEPROM, 32'h1000, 32'h10, WS_NONE, ATTR_NONE), 1'b0,
            '0);
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_ANY, 32'h10F0, 32'h20, WS_NONE, ATTR_NONE), 1'b0,
            '0);
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_EEPROM, 32'hFFFF_FF00, 32'h100, WS_NONE, ATTR_NONE),
            1'b0, '0);
    // zero size at zero covers the whole space
    add_row(mk_cmd(CMD_SET, 8'd1, MT_RAM, 32'd0, 32'd0, WS_WORD, ATTR_WR), 1'b1,
            status_only(ST_OK));
    add_row(mk_cmd(CMD_CHECK, 8'd0, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b0, '0);
    add_row(mk_cmd(CMD_SET, 8'd2, MT_EEPROM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WS_DWORD, ATTR_RW),
            1'b1, status_only(ST_OK));
    add_row(mk_cmd(CMD_GET, 8'd2, MT_ANY, 32'd0, 32'd0, WS_NONE, ATTR_NONE), 1'b0, '0);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 55) return $urandom_range(0, 32'h0000_FFFF);
    if (r < 85) return 32'h8000_0000 + $urandom_range(0, 32'h0000_FFFF);
    return 32'hFFFF_0000 + $urandom_range(0, 32'h0000_FFFF);
  endfunction

  function automatic logic [31:0] random_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'd0;
    if (r < 10) return $urandom;
    return $urandom_range(1, 32'h2000);
  endfunction

  function automatic logic [7:0] random_index();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(16, 255));
    return 8'($urandom_range(0, TABLE_ENTRIES - 1));
  endfunction

  // mostly sets and checks aimed at the regions already in the table
  function automatic region_cmd_t random_cmd();
    region_cmd_t c;
    int unsigned pick;
    int unsigned k;
    int unsigned mode;
    int unsigned off;
    logic [31:0] lo;
    logic [31:0] sz;
    c = mk_cmd(CMD_CHECK, 8'($urandom), 2'($urandom_range(0, 2)), random_addr(), random_len(),
               2'($urandom), 2'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      c.command = CMD_SET;
      c.index = random_index();
      if ($urandom_range(0, 11) == 0)
        c.mem_type = ($urandom_range(0, 1) != 0) ? MT_UNKNOWN : MT_ANY;
      else
        c.mem_type = 2'($urandom_range(1, 2));
      c.word_size  = ($urandom_range(0, 14) == 0) ? WS_NONE : 2'($urandom_range(1, 3));
      c.attributes = ($urandom_range(0, 14) == 0) ? ATTR_NONE : 2'($urandom_range(1, 3));
    end else if (pick < 42) begin
      c.command = CMD_GET;
      c.index = random_index();
    end else if (pick < 97) begin
      if ($urandom_range(0, 19) == 0) c.mem_type = MT_UNKNOWN;
      k  = $urandom_range(0, TABLE_ENTRIES - 1);
      lo = shadow_start[k];
      sz = shadow_size[k];
      if (shadow_type[k] != REGION_INVALID && sz != 0 && sz <= 32'h0010_0000) begin
        off  = $urandom_range(0, sz - 1);
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          c.address = lo + off;
          c.size    = $urandom_range(1, sz - off);
        end else if (mode < 8) begin
          c.address = lo - $urandom_range(1, 16);
          c.size    = $urandom_range(1, sz + 32);
        end else begin
          c.address = lo + off;
          c.size    = sz - off + $urandom_range(1, 16);
        end
      end
    end else begin
      c.command = CMD_UNUSED;
    end
    return c;
  endfunction

  // compare one popped result against the oldest expectation
  task automatic take_result();
    res_t want;
    result_count++;
    if (out_status < 3'd6) status_seen[out_status]++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result status", 32'(out_status), '0);
      return;
    end
    want = pending_results.pop_front();
    if (out_status !== want.status)
      report_mismatch("status", 32'(out_status), 32'(want.status));
    if (out_entry_type !== want.etype)
      report_mismatch("entry_type", 32'(out_entry_type), 32'(want.etype));
    if (out_entry_start !== want.start)
      report_mismatch("entry_start", out_entry_start, want.start);
    if (out_entry_size !== want.size) report_mismatch("entry_size", out_entry_size, want.size);
    if (out_entry_word_size !== want.wsize)
      report_mismatch("entry_word_size", 32'(out_entry_word_size), 32'(want.wsize));
    if (out_entry_attributes !== want.attr)
      report_mismatch("entry_attributes", 32'(out_entry_attributes), 32'(want.attr));
  endtask

  // result side: random stalls, one long hold-off, no stalls during the burst
  initial begin : result_side
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) take_result();
      if (!hold_done && accepted_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (accepted_items < BURST_FROM || accepted_items >= BURST_TO + 50)
          stall_left = gap_len();
      end
    end
  end

  // item side and end of run
  initial begin : item_side
    region_cmd_t c;
    res_t        predicted;
    int          total;
    int          g;
    clear_shadow();
    load_directed_rows();
    total = directed_rows.size() + RANDOM_ITEMS;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < total; k++) begin
      if (k < directed_rows.size()) c = directed_rows[k].cmd;
      else c = random_cmd();
      in_command    <= c.command;
      in_index      <= c.index;
      in_mem_type   <= c.mem_type;
      in_address    <= c.address;
      in_size       <= c.size;
      in_word_size  <= c.word_size;
      in_attributes <= c.attributes;
      push          <= 1'b1;
      do @(posedge clk); while (full !== 1'b0);
      accepted_items++;
      cmd_count[c.command]++;
      predict_region_op(c, predicted);
      if (k < directed_rows.size() && directed_rows[k].typed)
        pending_results.push_back(directed_rows[k].want);
      else
        pending_results.push_back(predicted);
      // idle between items, a full drain at PAUSE_AT; none while results are held back or in the burst
      if (k == PAUSE_AT) begin
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        g = gap_len();
        if (hold_left > 0 || (k >= BURST_FROM && k < BURST_TO)) g = 0;
        if (g > 0) begin
          push <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d items: %0d checks, %0d sets, %0d gets, %0d unknown commands",
             accepted_items, cmd_count[CMD_CHECK], cmd_count[CMD_SET], cmd_count[CMD_GET],
             cmd_count[CMD_UNUSED]);
    $display("tb: %0d results, ok/addr/type/range/wsize/attr = %0d/%0d/%0d/%0d/%0d/%0d",
             result_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
